/* hdl/quaternion_to_euler_degrees_core_defines.svh */
// Assertion macros shared by the checker of the quaternion to Euler core.
// Depends on nothing; expects clk and rst in the scope where a macro is used.
`ifndef QUATERNION_TO_EULER_DEGREES_CORE_DEFINES_SVH
`define QUATERNION_TO_EULER_DEGREES_CORE_DEFINES_SVH

// Check that cons holds whenever ante holds, outside reset.
`define QTE_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check that expr never holds, outside reset.
`define QTE_ASSERT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error(msg);

`endif

/* hdl/qte_pkg.sv */
// Package for the quaternion to Euler angle core: widths, codes, payload types,
// CORDIC step table and final angle rounding. Depends on nothing.
package qte_pkg;

  localparam int QUAT_W       = 16;
  localparam int ANG_W        = 15;
  localparam int POLE_W       = 2;
  localparam int FRAC_OUT     = 6;
  localparam int ACC_FRAC     = 20;
  localparam int PROD_FRAC    = 28;
  localparam int PROD_W       = 32;
  localparam int SUM_W        = 34;
  localparam int CMUL_W       = 46;
  localparam int ARG_W        = 35;
  localparam int WORK_W       = 45;
  localparam int NORM_BIT     = 41;
  localparam int NORM_STAGES  = 6;
  localparam int CORDIC_STEPS = 24;
  localparam int Z_W          = 32;
  localparam int S_ABS_W      = 29;
  localparam int ISQ_STEPS    = 29;
  localparam int ISQ_W        = 60;
  localparam int ATAN_REGS    = 1 + NORM_STAGES + CORDIC_STEPS;
  localparam int FRONT_REGS   = 6;
  localparam int PIPE_REGS    = FRONT_REGS + ISQ_STEPS + ATAN_REGS + 1;
  localparam int RND_SH       = ACC_FRAC - FRAC_OUT;
  localparam int FIN_W        = Z_W + 1 - RND_SH;
  localparam int FULL_TURN_I  = 360 << FRAC_OUT;

  localparam logic [POLE_W-1:0] POLE_NONE  = 2'd0;
  localparam logic [POLE_W-1:0] POLE_NORTH = 2'd1;
  localparam logic [POLE_W-1:0] POLE_SOUTH = 2'd2;

  localparam logic [ANG_W-1:0] FULL_TURN   = ANG_W'(FULL_TURN_I);
  localparam logic [ANG_W-1:0] PITCH_NORTH = ANG_W'(90 << FRAC_OUT);
  localparam logic [ANG_W-1:0] PITCH_SOUTH = ANG_W'(270 << FRAC_OUT);

  localparam logic signed [Z_W-1:0] Z_90  = Z_W'(90 * (1 << ACC_FRAC));
  localparam logic signed [Z_W-1:0] Z_180 = Z_W'(180 * (1 << ACC_FRAC));

  typedef struct packed {
    logic signed [QUAT_W-1:0] quat_x;
    logic signed [QUAT_W-1:0] quat_y;
    logic signed [QUAT_W-1:0] quat_z;
    logic signed [QUAT_W-1:0] quat_w;
  } quat_t;

  typedef struct packed {
    logic [ANG_W-1:0]  pitch_deg;
    logic [ANG_W-1:0]  yaw_deg;
    logic [ANG_W-1:0]  roll_deg;
    logic [POLE_W-1:0] pole;
  } euler_t;

  // atan(2^-i) in degrees * 2^20, rounded to nearest
  function automatic logic signed [Z_W-1:0] step_angle(input int idx);
    case (idx)
      0:  step_angle = Z_W'(47185920);
      1:  step_angle = Z_W'(27855475);
      2:  step_angle = Z_W'(14718068);
      3:  step_angle = Z_W'(7471121);
      4:  step_angle = Z_W'(3750058);
      5:  step_angle = Z_W'(1876857);
      6:  step_angle = Z_W'(938658);
      7:  step_angle = Z_W'(469357);
      8:  step_angle = Z_W'(234682);
      9:  step_angle = Z_W'(117342);
      10: step_angle = Z_W'(58671);
      11: step_angle = Z_W'(29335);
      12: step_angle = Z_W'(14668);
      13: step_angle = Z_W'(7334);
      14: step_angle = Z_W'(3667);
      15: step_angle = Z_W'(1833);
      16: step_angle = Z_W'(917);
      17: step_angle = Z_W'(458);
      18: step_angle = Z_W'(229);
      19: step_angle = Z_W'(115);
      20: step_angle = Z_W'(57);
      21: step_angle = Z_W'(29);
      22: step_angle = Z_W'(14);
      23: step_angle = Z_W'(7);
      default: step_angle = '0;
    endcase
  endfunction

  // Round degrees * 2^20 to the output format, ties up, then wrap into 0..360.
  function automatic logic [ANG_W-1:0] finish_angle(input logic signed [Z_W:0] a);
    logic signed [Z_W:0]   r;
    logic signed [FIN_W-1:0] v;
    r = a + (Z_W+1)'(1 << (RND_SH - 1));
    v = FIN_W'(r >>> RND_SH);
    if (v < 0) v = v + FIN_W'(FULL_TURN_I);
    if (v > FIN_W'(FULL_TURN_I)) v = v - FIN_W'(FULL_TURN_I);
    return v[ANG_W-1:0];
  endfunction

endpackage

/* hdl/qte_atan2.sv */
// Pipelined atan2 in degrees * 2^20: half-plane fold, normalizing shift, CORDIC.
// Depends on qte_pkg.
module qte_atan2 import qte_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  logic signed [ARG_W-1:0] in_y,
  input  logic signed [ARG_W-1:0] in_x,
  output logic                    out_valid,
  output logic signed [Z_W-1:0]   out_z
);

  localparam int LAST = ATAN_REGS - 1;

  logic                     st_valid   [0:LAST];
  logic                     st_special [0:LAST];
  logic signed [WORK_W-1:0] st_x       [0:LAST];
  logic signed [WORK_W-1:0] st_y       [0:LAST];
  logic signed [Z_W-1:0]    st_z       [0:LAST];
  logic [WORK_W-1:0]        st_m       [0:NORM_STAGES-1];

  logic signed [ARG_W-1:0] fx, fy;
  logic [ARG_W-1:0]        fxu, fay, fm;
  logic signed [Z_W-1:0]   fz;
  logic                    fsp;

  // fold into the right half plane; zero x is answered directly
  always_comb begin
    fsp = (in_x == '0);
    fx  = in_x;
    fy  = in_y;
    fz  = '0;
    if (fsp) begin
      if (in_y > 0) fz = Z_90;
      else if (in_y < 0) fz = -Z_90;
    end else if (in_x < 0) begin
      fz = (in_y >= 0) ? Z_180 : -Z_180;
      fx = -in_x;
      fy = -in_y;
    end
    fay = (fy < 0) ? -fy : fy;
    fxu = fx;
    fm  = (fxu > fay) ? fxu : fay;
  end

  always_ff @(posedge clk) begin
    if (rst) st_valid[0] <= 1'b0;
    else st_valid[0] <= in_valid;
    st_special[0] <= fsp;
    st_x[0]       <= WORK_W'(fx);
    st_y[0]       <= WORK_W'(fy);
    st_z[0]       <= fz;
    st_m[0]       <= WORK_W'(fm);
  end

  // shift left by 32, 16, ... 1 while the larger magnitude stays below 2^41
  for (genvar k = 0; k < NORM_STAGES; k++) begin : g_norm
    localparam int SH = 1 << (NORM_STAGES - 1 - k);
    logic go;
    assign go = ((st_m[k] >> (NORM_BIT - SH)) == '0);
    always_ff @(posedge clk) begin
      if (rst) st_valid[k+1] <= 1'b0;
      else st_valid[k+1] <= st_valid[k];
      st_special[k+1] <= st_special[k];
      st_x[k+1]       <= go ? (st_x[k] <<< SH) : st_x[k];
      st_y[k+1]       <= go ? (st_y[k] <<< SH) : st_y[k];
      st_z[k+1]       <= st_z[k];
    end
    if (k < NORM_STAGES - 1) begin : g_m
      always_ff @(posedge clk) begin
        st_m[k+1] <= go ? (st_m[k] << SH) : st_m[k];
      end
    end
  end

  // vectoring CORDIC: drive y toward zero, accumulate the angle
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    localparam int P = NORM_STAGES + i;
    logic signed [WORK_W-1:0] xs, ys;
    logic                     neg;
    assign xs  = st_x[P] >>> i;
    assign ys  = st_y[P] >>> i;
    assign neg = st_y[P][WORK_W-1];
    always_ff @(posedge clk) begin
      if (rst) st_valid[P+1] <= 1'b0;
      else st_valid[P+1] <= st_valid[P];
      st_special[P+1] <= st_special[P];
      if (neg) begin
        st_x[P+1] <= st_x[P] - ys;
        st_y[P+1] <= st_y[P] + xs;
      end else begin
        st_x[P+1] <= st_x[P] + ys;
        st_y[P+1] <= st_y[P] - xs;
      end
      if (st_special[P]) st_z[P+1] <= st_z[P];
      else if (neg) st_z[P+1] <= st_z[P] - step_angle(i);
      else st_z[P+1] <= st_z[P] + step_angle(i);
    end
  end

  assign out_valid = st_valid[LAST];
  assign out_z     = st_z[LAST];

endmodule

/* hdl/quaternion_to_euler_degrees_core.sv */
// Quaternion to Euler angle converter, top level. Depends on qte_pkg and
// qte_atan2 (three instances).
//
// Takes one quaternion (x, y, z, w, signed Q2.14) per transfer and returns
// pitch, yaw and roll in degrees * 64, each wrapped into 0..360, plus a pole
// code for the gimbal-lock cases. A transfer is taken on any clock where start
// is high and busy is low; busy is high only around reset. The block accepts
// one quaternion every clock while busy is low, and every result comes out in
// order as a one-cycle done strobe with euler valid in that cycle. The
// receiver cannot hold results off, and nothing inside ever stalls. The
// pipeline is made of six front stages (products, sums, pole test and the
// pitch sine), a 29-stage square-root pipeline that forms the cosine for the
// pitch arcsine, and three 31-stage atan2 units (fold, six shift stages, 24
// CORDIC steps) that run side by side, plus the output register.
module quaternion_to_euler_degrees_core import qte_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   start,
  output logic   busy,
  input  quat_t  quat,
  output logic   done,
  output euler_t euler
);

  typedef struct packed {
    logic [POLE_W-1:0]       pole;
    logic signed [ARG_W-1:0] s;
    logic signed [ARG_W-1:0] yaw_y;
    logic signed [ARG_W-1:0] yaw_x;
    logic signed [ARG_W-1:0] roll_y;
    logic signed [ARG_W-1:0] roll_x;
  } side_t;

  localparam logic signed [SUM_W-1:0] ONE_Q   = SUM_W'(64'sd1 << PROD_FRAC);
  localparam logic [ISQ_W-1:0]        ISQ_TOP = ISQ_W'(1) << (2 * PROD_FRAC);

  logic accept;

  // hold busy through reset so no transfer is taken then
  always_ff @(posedge clk) begin
    busy <= rst;
  end

  assign accept = start && !busy;

  // stage 0: capture the transfer
  logic  v0;
  quat_t q0;
  always_ff @(posedge clk) begin
    if (rst) v0 <= 1'b0;
    else v0 <= accept;
    q0 <= quat;
  end

  // stage 1: all component products, exact Q.28
  logic v1;
  logic signed [PROD_W-1:0] p_xx, p_yy, p_zz, p_ww, p_xw, p_yz, p_wy, p_zx, p_wz, p_xy;
  logic signed [QUAT_W-1:0] r1_x, r1_y;
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else v1 <= v0;
    p_xx <= q0.quat_x * q0.quat_x;
    p_yy <= q0.quat_y * q0.quat_y;
    p_zz <= q0.quat_z * q0.quat_z;
    p_ww <= q0.quat_w * q0.quat_w;
    p_xw <= q0.quat_x * q0.quat_w;
    p_yz <= q0.quat_y * q0.quat_z;
    p_wy <= q0.quat_w * q0.quat_y;
    p_zx <= q0.quat_z * q0.quat_x;
    p_wz <= q0.quat_w * q0.quat_z;
    p_xy <= q0.quat_x * q0.quat_y;
    r1_x <= q0.quat_x;
    r1_y <= q0.quat_y;
  end

  // stage 2: norm, pole test value, atan2 arguments for yaw and roll
  logic v2;
  logic signed [SUM_W-1:0] t2_unit, t2_test, t2_yn, t2_yd, t2_rn, t2_rd;
  logic signed [QUAT_W-1:0] r2_x, r2_y;
  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else v2 <= v1;
    t2_unit <= SUM_W'(p_xx) + SUM_W'(p_yy) + SUM_W'(p_zz) + SUM_W'(p_ww);
    t2_test <= SUM_W'(p_xw) - SUM_W'(p_yz);
    t2_yn   <= (SUM_W'(p_wy) + SUM_W'(p_zx)) <<< 1;
    t2_yd   <= ONE_Q - ((SUM_W'(p_xx) + SUM_W'(p_yy)) <<< 1);
    t2_rn   <= (SUM_W'(p_wz) + SUM_W'(p_xy)) <<< 1;
    t2_rd   <= ONE_Q - ((SUM_W'(p_zz) + SUM_W'(p_xx)) <<< 1);
    r2_x    <= r1_x;
    r2_y    <= r1_y;
  end

  // stage 3: scale for the 0.4995 threshold, saturate the pitch sine
  logic v3;
  logic signed [CMUL_W-1:0] t3_t2k, t3_u999;
  logic signed [SUM_W-1:0]  s2;
  logic signed [ARG_W-1:0]  t3_s;
  logic [S_ABS_W-1:0]       t3_sabs;
  logic signed [SUM_W-1:0]  t3_yn, t3_yd, t3_rn, t3_rd;
  logic signed [QUAT_W-1:0] r3_x, r3_y;

  always_comb begin
    s2 = t2_test <<< 1;
    if (s2 > ONE_Q) s2 = ONE_Q;
    if (s2 < -ONE_Q) s2 = -ONE_Q;
  end

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else v3 <= v2;
    t3_t2k  <= CMUL_W'(t2_test) * CMUL_W'(2000);
    t3_u999 <= CMUL_W'(t2_unit) * CMUL_W'(999);
    t3_s    <= ARG_W'(s2);
    t3_sabs <= S_ABS_W'((s2 < 0) ? -s2 : s2);
    t3_yn   <= t2_yn;
    t3_yd   <= t2_yd;
    t3_rn   <= t2_rn;
    t3_rd   <= t2_rd;
    r3_x    <= r2_x;
    r3_y    <= r2_y;
  end

  // stage 4: pole decision, pick yaw arguments, square the sine
  logic v4;
  logic [ISQ_W-1:0]  t4_ssq;
  side_t             t4_side;
  logic [POLE_W-1:0] pole3;

  always_comb begin
    pole3 = POLE_NONE;
    if (t3_t2k > t3_u999) pole3 = POLE_NORTH;
    else if (t3_t2k < -t3_u999) pole3 = POLE_SOUTH;
  end

  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else v4 <= v3;
    t4_ssq         <= ISQ_W'(t3_sabs) * ISQ_W'(t3_sabs);
    t4_side.pole   <= pole3;
    t4_side.s      <= t3_s;
    t4_side.yaw_y  <= (pole3 != POLE_NONE) ? ARG_W'(r3_y) : ARG_W'(t3_yn);
    t4_side.yaw_x  <= (pole3 != POLE_NONE) ? ARG_W'(r3_x) : ARG_W'(t3_yd);
    t4_side.roll_y <= ARG_W'(t3_rn);
    t4_side.roll_x <= ARG_W'(t3_rd);
  end

  // stage 5 and on: restoring square root of 1 - s^2, one root bit per stage
  logic               sq_valid [0:ISQ_STEPS];
  logic [ISQ_W-1:0]   sq_rem   [0:ISQ_STEPS];
  logic [S_ABS_W-1:0] sq_root  [0:ISQ_STEPS];
  side_t              sq_side  [0:ISQ_STEPS];

  always_ff @(posedge clk) begin
    if (rst) sq_valid[0] <= 1'b0;
    else sq_valid[0] <= v4;
    sq_rem[0]  <= ISQ_TOP - t4_ssq;
    sq_root[0] <= '0;
    sq_side[0] <= t4_side;
  end

  for (genvar j = 0; j < ISQ_STEPS; j++) begin : g_isqrt
    localparam int BIT = ISQ_STEPS - 1 - j;
    logic [ISQ_W-1:0] cand;
    assign cand = (ISQ_W'(sq_root[j]) << (BIT + 1)) + (ISQ_W'(1) << (2 * BIT));
    always_ff @(posedge clk) begin
      if (rst) sq_valid[j+1] <= 1'b0;
      else sq_valid[j+1] <= sq_valid[j];
      sq_side[j+1] <= sq_side[j];
      if (sq_rem[j] >= cand) begin
        sq_rem[j+1]  <= sq_rem[j] - cand;
        sq_root[j+1] <= sq_root[j] | (S_ABS_W'(1) << BIT);
      end else begin
        sq_rem[j+1]  <= sq_rem[j];
        sq_root[j+1] <= sq_root[j];
      end
    end
  end

  // three atan2 units in lockstep
  logic                    pitch_valid, yaw_valid, roll_valid;
  logic signed [Z_W-1:0]   z_pitch, z_yaw, z_roll;
  logic signed [ARG_W-1:0] cos_arg;

  assign cos_arg = ARG_W'(sq_root[ISQ_STEPS]);

  qte_atan2 u_pitch (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sq_valid[ISQ_STEPS]),
    .in_y      (sq_side[ISQ_STEPS].s),
    .in_x      (cos_arg),
    .out_valid (pitch_valid),
    .out_z     (z_pitch)
  );

  qte_atan2 u_yaw (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sq_valid[ISQ_STEPS]),
    .in_y      (sq_side[ISQ_STEPS].yaw_y),
    .in_x      (sq_side[ISQ_STEPS].yaw_x),
    .out_valid (yaw_valid),
    .out_z     (z_yaw)
  );

  qte_atan2 u_roll (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sq_valid[ISQ_STEPS]),
    .in_y      (sq_side[ISQ_STEPS].roll_y),
    .in_x      (sq_side[ISQ_STEPS].roll_x),
    .out_valid (roll_valid),
    .out_z     (z_roll)
  );

  // carry the pole code alongside the atan2 units
  logic [POLE_W-1:0] pole_line [0:ATAN_REGS-1];
  always_ff @(posedge clk) begin
    pole_line[0] <= sq_side[ISQ_STEPS].pole;
  end
  for (genvar d = 1; d < ATAN_REGS; d++) begin : g_pole
    always_ff @(posedge clk) begin
      pole_line[d] <= pole_line[d-1];
    end
  end

  // output register: round, wrap, apply the pole overrides
  logic signed [Z_W:0] yaw2;
  logic                out_valid;
  euler_t              euler_next;

  assign out_valid = pitch_valid && yaw_valid && roll_valid;
  assign yaw2      = (Z_W+1)'(z_yaw) <<< 1;

  always_comb begin
    euler_next.pole = pole_line[ATAN_REGS-1];
    case (pole_line[ATAN_REGS-1])
      POLE_NORTH: begin
        euler_next.pitch_deg = PITCH_NORTH;
        euler_next.yaw_deg   = finish_angle(yaw2);
        euler_next.roll_deg  = '0;
      end
      POLE_SOUTH: begin
        euler_next.pitch_deg = PITCH_SOUTH;
        euler_next.yaw_deg   = finish_angle(-yaw2);
        euler_next.roll_deg  = '0;
      end
      default: begin
        euler_next.pitch_deg = finish_angle((Z_W+1)'(z_pitch));
        euler_next.yaw_deg   = finish_angle((Z_W+1)'(z_yaw));
        euler_next.roll_deg  = finish_angle((Z_W+1)'(z_roll));
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= out_valid;
    euler <= euler_next;
  end

endmodule

/* hdl/qte_checker.sv */
// Port-level checker for the quaternion to Euler core, bound to the top level.
// Depends on qte_pkg and quaternion_to_euler_degrees_core_defines.svh.
`include "quaternion_to_euler_degrees_core_defines.svh"

module qte_checker import qte_pkg::*; (
  input logic   clk,
  input logic   rst,
  input logic   start,
  input logic   busy,
  input quat_t  quat,
  input logic   done,
  input euler_t euler
);

  `QTE_ASSERT_IMPLIES(a_fixed_latency, done, $past(start && !busy, PIPE_REGS), "result without transfer at fixed latency")
  `QTE_ASSERT_IMPLIES(a_north_pole, done && (euler.pole == POLE_NORTH), (euler.pitch_deg == PITCH_NORTH) && (euler.roll_deg == '0), "north pole angles wrong")
  `QTE_ASSERT_IMPLIES(a_south_pole, done && (euler.pole == POLE_SOUTH), (euler.pitch_deg == PITCH_SOUTH) && (euler.roll_deg == '0), "south pole angles wrong")
  `QTE_ASSERT_NEVER(a_angle_range, done && ((euler.pitch_deg > FULL_TURN) || (euler.yaw_deg > FULL_TURN) || (euler.roll_deg > FULL_TURN)), "angle beyond full turn")

endmodule

bind quaternion_to_euler_degrees_core qte_checker u_qte_checker (.*);
